>>> rtl/utr_pkg.sv
// Shared types and constants for the usage trend regression block.
package utr_pkg;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SADD
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
    logic      a_neg;
    logic      b_neg;
  } arith_ctl_t;

  typedef struct packed {
    logic done;
    logic res_neg;
  } arith_sts_t;

  typedef struct packed {
    logic clear;
    logic start;
  } sums_ctl_t;

  localparam logic [1:0]  STATUS_ACCEPTED = 2'd0;
  localparam logic [1:0]  STATUS_REJECTED = 2'd1;
  localparam logic [1:0]  STATUS_CLEARED  = 2'd2;

  localparam logic [16:0] R2_ONE       = 17'd65536;
  localparam logic [39:0] SLOPE_EPS_INV = 40'd1000000000000;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 216;

endpackage

>>> rtl/utr_sums.sv
// Running sums of time, usage and their products, updated with one 32x32 multiplier.
module utr_sums #(
  parameter int NB  = 9,
  parameter int SW1 = 40,
  parameter int SW2 = 72
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utr_pkg::sums_ctl_t  ctl_i,
  input  logic [31:0]         t_i,
  input  logic [31:0]         u_i,
  input  logic [31:0]         cap_i,
  output logic                done_o,
  output logic [NB-1:0]       count_o,
  output logic [SW1-1:0]      st_o,
  output logic [SW1-1:0]      su_o,
  output logic [SW2-1:0]      stt_o,
  output logic [SW2-1:0]      stu_o,
  output logic [SW2-1:0]      suu_o,
  output logic [31:0]         cap_o
);
  import utr_pkg::*;

  typedef enum logic [1:0] {
    PH_TT,
    PH_TU,
    PH_UU,
    PH_LAST
  } phase_e;

  phase_e        phase_q;
  logic          busy_q;
  logic          done_q;
  logic [NB-1:0] count_q;
  logic [SW1-1:0] st_q, su_q;
  logic [SW2-1:0] stt_q, stu_q, suu_q;
  logic [31:0]   cap_q, t_q, u_q, ma, mb;
  logic [63:0]   prod_q;

  always_comb begin
    ma = t_q;
    mb = u_q;
    case (phase_q)
      PH_TT:   mb = t_q;
      PH_UU:   ma = u_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TT;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
      st_q    <= '0;
      su_q    <= '0;
      stt_q   <= '0;
      stu_q   <= '0;
      suu_q   <= '0;
      cap_q   <= '0;
    end else begin
      done_q <= 1'b0;
      prod_q <= {32'd0, ma} * {32'd0, mb};
      if (ctl_i.clear) begin
        busy_q  <= 1'b0;
        count_q <= '0;
        st_q    <= '0;
        su_q    <= '0;
        stt_q   <= '0;
        stu_q   <= '0;
        suu_q   <= '0;
        cap_q   <= '0;
      end else if (ctl_i.start) begin
        t_q     <= t_i;
        u_q     <= u_i;
        cap_q   <= cap_i;
        st_q    <= st_q + SW1'(t_i);
        su_q    <= su_q + SW1'(u_i);
        count_q <= count_q + NB'(1);
        phase_q <= PH_TT;
        busy_q  <= 1'b1;
      end else if (busy_q) begin
        unique case (phase_q)
          PH_TT: phase_q <= PH_TU;
          PH_TU: begin
            stt_q   <= stt_q + SW2'(prod_q);
            phase_q <= PH_UU;
          end
          PH_UU: begin
            stu_q   <= stu_q + SW2'(prod_q);
            phase_q <= PH_LAST;
          end
          default: begin
            suu_q  <= suu_q + SW2'(prod_q);
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        endcase
      end
    end
  end

  assign done_o  = done_q;
  assign count_o = count_q;
  assign st_o    = st_q;
  assign su_o    = su_q;
  assign stt_o   = stt_q;
  assign stu_o   = stu_q;
  assign suu_o   = suu_q;
  assign cap_o   = cap_q;

endmodule

>>> rtl/utr_arith.sv
// Shared wide add/subtract unit run as bit-serial multiplier, divider and signed adder.
module utr_arith #(
  parameter int BW = 180
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  utr_pkg::arith_ctl_t  ctl_i,
  input  logic [BW-1:0]        a_i,
  input  logic [BW-1:0]        b_i,
  output utr_pkg::arith_sts_t  sts_o,
  output logic [BW-1:0]        res_o
);
  import utr_pkg::*;

  localparam int CW = $clog2(BW + 1);

  typedef enum logic [1:0] {
    A_IDLE,
    A_RUN,
    A_SWAP
  } astate_e;

  astate_e     state_q;
  arith_op_e   op_q;
  logic        an_q, bn_q, neg_q, done_q;
  logic [BW-1:0] acc_q, x_q, y_q;
  logic [CW-1:0] cnt_q;
  logic [BW+1:0] p, q, sum;
  logic        sub, borrow;

  always_comb begin
    p   = '0;
    q   = '0;
    sub = 1'b0;
    case (op_q)
      OP_MUL: begin
        p = {1'b0, acc_q, 1'b0};
        q = y_q[BW-1] ? {2'b00, x_q} : '0;
      end
      OP_DIV: begin
        p   = {1'b0, acc_q, y_q[BW-1]};
        q   = {2'b00, x_q};
        sub = 1'b1;
      end
      default: begin
        if (state_q == A_SWAP) begin
          p   = {2'b00, y_q};
          q   = {2'b00, x_q};
          sub = 1'b1;
        end else begin
          p   = {2'b00, x_q};
          q   = {2'b00, y_q};
          sub = an_q != bn_q;
        end
      end
    endcase
    sum    = sub ? p - q : p + q;
    borrow = sum[BW+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      op_q    <= OP_MUL;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        A_IDLE: begin
          if (ctl_i.start) begin
            op_q  <= ctl_i.op;
            an_q  <= ctl_i.a_neg;
            bn_q  <= ctl_i.b_neg;
            cnt_q <= CW'(BW);
            acc_q <= '0;
            if (ctl_i.op == OP_DIV) begin
              x_q <= b_i;
              y_q <= a_i;
            end else begin
              x_q <= a_i;
              y_q <= b_i;
            end
            state_q <= A_RUN;
          end
        end
        A_RUN: begin
          case (op_q)
            OP_MUL: begin
              acc_q <= sum[BW-1:0];
              y_q   <= y_q << 1;
              cnt_q <= cnt_q - CW'(1);
              if (cnt_q == CW'(1)) begin
                done_q  <= 1'b1;
                state_q <= A_IDLE;
              end
            end
            OP_DIV: begin
              acc_q <= borrow ? p[BW-1:0] : sum[BW-1:0];
              y_q   <= {y_q[BW-2:0], ~borrow};
              cnt_q <= cnt_q - CW'(1);
              if (cnt_q == CW'(1)) begin
                done_q  <= 1'b1;
                state_q <= A_IDLE;
              end
            end
            default: begin
              if (sub && borrow) begin
                state_q <= A_SWAP;
              end else begin
                acc_q   <= sum[BW-1:0];
                neg_q   <= an_q;
                done_q  <= 1'b1;
                state_q <= A_IDLE;
              end
            end
          endcase
        end
        default: begin
          acc_q   <= sum[BW-1:0];
          neg_q   <= bn_q;
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
      endcase
    end
  end

  assign res_o         = (op_q == OP_DIV) ? y_q : acc_q;
  assign sts_o.done    = done_q;
  assign sts_o.res_neg = neg_q && (acc_q != '0);

endmodule

>>> rtl/usage_trend_regression.sv
// Top level of the usage trend regression block: request handling and fit sequencer.
//
// Requests arrive on the s_axis channel: tuser selects clear (1) or add sample (0),
// tdata carries sample time, used bytes, total bytes and the projection time.
// Every request produces exactly one result on the m_axis channel with the status,
// the fit flag, slope, intercept, R-squared, projected full time and projected usage.
// A sample is first folded into the running sums. The fit then runs up to
// 25 operations on one shared bit-serial unit, BW = 148 + 4 * log2(MAX_POINTS) wide;
// clears and series with fewer than two points skip the fit. s_axis_tready is high
// only while the sequencer is idle. The result sits in an output register, so a new
// request is accepted while the receiver stalls; its own result waits until the
// previous one is taken. Reset empties the series and drops any pending result.
module usage_trend_regression #(
  parameter int MAX_POINTS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // time[31:0], used[63:32], total[95:64], future_time[127:96]
  input  logic [utr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // req_type
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status[1:0], fit_valid[2], slope[66:3], intercept[130:67], rsq[147:131],
  // full_time[179:148], projected_used[211:180], zero[215:212]
  output logic [utr_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import utr_pkg::*;

  localparam int LG  = $clog2(MAX_POINTS);
  localparam int NB  = $clog2(MAX_POINTS + 1);
  localparam int SW1 = 32 + LG;
  localparam int SW2 = 64 + LG;
  localparam int BW  = 148 + 4 * LG;

  typedef enum logic [5:0] {
    ST_IDLE, ST_SUMS, ST_CHECK, ST_OUT,
    ST_D1, ST_D2, ST_D3, ST_N1, ST_N2, ST_N3, ST_I1, ST_I2, ST_I3,
    ST_E1, ST_E2, ST_E3, ST_SLOPE, ST_ICPT, ST_R1, ST_R2, ST_R3,
    ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_P1, ST_P2, ST_P3
  } state_e;

  state_e        state_q, full_next;
  logic          issued_q, out_valid_q, calc, accept;
  sums_ctl_t     sctl;
  arith_ctl_t    actl;
  arith_sts_t    asts;
  logic          sdone;
  logic [NB-1:0] count;
  logic [SW1-1:0] st, su;
  logic [SW2-1:0] stt, stu, suu;
  logic [31:0]   cap, f_q;
  logic [BW-1:0] op_a, op_b, ares;
  logic [BW-1:0] t1_q, t2_q, d_q, nn_q, ni_q, e_q;
  logic          nn_neg_q, ni_neg_q, e_bad_q, valid_q;
  logic [1:0]    status_q;
  logic [63:0]   slope_q, icpt_q;
  logic [16:0]   r2_q;
  logic [31:0]   full_q, proj_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  function automatic logic [63:0] sat_s64(input logic [BW-1:0] m, input logic neg);
    logic [63:0] mag;
    logic        hi;
    mag = m[63:0];
    hi  = |m[BW-1:64];
    if (!neg) begin
      sat_s64 = (hi || mag[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : mag;
    end else begin
      sat_s64 = (hi || mag > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : ~mag + 64'd1;
    end
  endfunction

  function automatic logic [31:0] sat_u32(input logic [BW-1:0] m);
    sat_u32 = (|m[BW-1:32]) ? 32'hFFFF_FFFF : m[31:0];
  endfunction

  function automatic logic [16:0] sat_r2(input logic [BW-1:0] m);
    sat_r2 = ((|m[BW-1:17]) || m[16:0] > R2_ONE) ? R2_ONE : m[16:0];
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sctl.clear    = accept && s_axis_tuser;
  assign sctl.start    = accept && !s_axis_tuser && (count < NB'(MAX_POINTS));

  utr_sums #(.NB(NB), .SW1(SW1), .SW2(SW2)) u_sums (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sctl),
    .t_i     (s_axis_tdata[31:0]),
    .u_i     (s_axis_tdata[63:32]),
    .cap_i   (s_axis_tdata[95:64]),
    .done_o  (sdone),
    .count_o (count),
    .st_o    (st),
    .su_o    (su),
    .stt_o   (stt),
    .stu_o   (stu),
    .suu_o   (suu),
    .cap_o   (cap)
  );

  utr_arith #(.BW(BW)) u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (actl),
    .a_i    (op_a),
    .b_i    (op_b),
    .sts_o  (asts),
    .res_o  (ares)
  );

  assign calc = !(state_q == ST_IDLE || state_q == ST_SUMS ||
                  state_q == ST_CHECK || state_q == ST_OUT);
  assign full_next = (!nn_neg_q && nn_q != '0 && cap != 32'd0) ? ST_F1 : ST_P1;

  always_comb begin
    actl       = '0;
    actl.op    = OP_MUL;
    op_a       = '0;
    op_b       = '0;
    unique case (state_q)
      ST_D1:    begin op_a = BW'(count); op_b = BW'(stt); end
      ST_D2:    begin op_a = BW'(st);    op_b = BW'(st);  end
      ST_N1:    begin op_a = BW'(count); op_b = BW'(stu); end
      ST_N2:    begin op_a = BW'(st);    op_b = BW'(su);  end
      ST_I1:    begin op_a = BW'(su);    op_b = BW'(stt); end
      ST_I2:    begin op_a = BW'(st);    op_b = BW'(stu); end
      ST_E1:    begin op_a = BW'(count); op_b = BW'(suu); end
      ST_E2:    begin op_a = BW'(su);    op_b = BW'(su);  end
      ST_D3, ST_N3, ST_I3, ST_E3: begin
        actl.op    = OP_SADD;
        actl.b_neg = 1'b1;
        op_a       = t1_q;
        op_b       = t2_q;
      end
      ST_SLOPE: begin actl.op = OP_DIV; op_a = nn_q << 32; op_b = d_q; end
      ST_ICPT:  begin actl.op = OP_DIV; op_a = ni_q << 16; op_b = d_q; end
      ST_R1:    begin op_a = nn_q; op_b = nn_q; end
      ST_R2:    begin op_a = d_q;  op_b = e_q;  end
      ST_R3:    begin actl.op = OP_DIV; op_a = t1_q << 16; op_b = t2_q; end
      ST_F1:    begin op_a = nn_q; op_b = BW'(SLOPE_EPS_INV); end
      ST_F2: begin
        actl.op    = OP_SADD;
        actl.b_neg = 1'b1;
        op_a       = d_q;
        op_b       = t1_q;
      end
      ST_F3:    begin op_a = BW'(cap); op_b = d_q; end
      ST_F4: begin
        actl.op    = OP_SADD;
        actl.b_neg = !ni_neg_q;
        op_a       = t1_q;
        op_b       = ni_q;
      end
      ST_F5:    begin actl.op = OP_DIV; op_a = t2_q; op_b = nn_q; end
      ST_P1:    begin op_a = nn_q; op_b = BW'(f_q); end
      ST_P2: begin
        actl.op    = OP_SADD;
        actl.a_neg = nn_neg_q;
        actl.b_neg = ni_neg_q;
        op_a       = t1_q;
        op_b       = ni_q;
      end
      ST_P3:    begin actl.op = OP_DIV; op_a = t2_q; op_b = d_q; end
      default: ;
    endcase
    actl.start = calc && !issued_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            f_q     <= s_axis_tdata[127:96];
            valid_q <= 1'b0;
            slope_q <= '0;
            icpt_q  <= '0;
            r2_q    <= '0;
            full_q  <= '0;
            proj_q  <= '0;
            if (s_axis_tuser) begin
              status_q <= STATUS_CLEARED;
              state_q  <= ST_CHECK;
            end else if (count >= NB'(MAX_POINTS)) begin
              status_q <= STATUS_REJECTED;
              state_q  <= ST_CHECK;
            end else begin
              status_q <= STATUS_ACCEPTED;
              state_q  <= ST_SUMS;
            end
          end
        end
        ST_SUMS: begin
          if (sdone) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: state_q <= (count >= NB'(2)) ? ST_D1 : ST_OUT;
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_data_q  <= {4'd0, proj_q, full_q, r2_q, icpt_q, slope_q, valid_q, status_q};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          if (asts.done) begin
            issued_q <= 1'b0;
            case (state_q)
              ST_D1: begin t1_q <= ares; state_q <= ST_D2; end
              ST_D2: begin t2_q <= ares; state_q <= ST_D3; end
              ST_D3: begin
                d_q <= ares;
                if (asts.res_neg || ares == '0) begin
                  state_q <= ST_OUT;
                end else begin
                  valid_q <= 1'b1;
                  state_q <= ST_N1;
                end
              end
              ST_N1: begin t1_q <= ares; state_q <= ST_N2; end
              ST_N2: begin t2_q <= ares; state_q <= ST_N3; end
              ST_N3: begin nn_q <= ares; nn_neg_q <= asts.res_neg; state_q <= ST_I1; end
              ST_I1: begin t1_q <= ares; state_q <= ST_I2; end
              ST_I2: begin t2_q <= ares; state_q <= ST_I3; end
              ST_I3: begin ni_q <= ares; ni_neg_q <= asts.res_neg; state_q <= ST_E1; end
              ST_E1: begin t1_q <= ares; state_q <= ST_E2; end
              ST_E2: begin t2_q <= ares; state_q <= ST_E3; end
              ST_E3: begin
                e_q     <= ares;
                e_bad_q <= asts.res_neg || ares == '0;
                state_q <= ST_SLOPE;
              end
              ST_SLOPE: begin slope_q <= sat_s64(ares, nn_neg_q); state_q <= ST_ICPT; end
              ST_ICPT: begin
                icpt_q <= sat_s64(ares, ni_neg_q);
                if (e_bad_q) begin
                  r2_q    <= R2_ONE;
                  state_q <= full_next;
                end else begin
                  state_q <= ST_R1;
                end
              end
              ST_R1: begin t1_q <= ares; state_q <= ST_R2; end
              ST_R2: begin t2_q <= ares; state_q <= ST_R3; end
              ST_R3: begin r2_q <= sat_r2(ares); state_q <= full_next; end
              ST_F1: begin t1_q <= ares; state_q <= ST_F2; end
              ST_F2: state_q <= asts.res_neg ? ST_F3 : ST_P1;
              ST_F3: begin t1_q <= ares; state_q <= ST_F4; end
              ST_F4: begin
                t2_q    <= ares;
                state_q <= (!asts.res_neg && ares != '0) ? ST_F5 : ST_P1;
              end
              ST_F5: begin full_q <= sat_u32(ares); state_q <= ST_P1; end
              ST_P1: begin t1_q <= ares; state_q <= ST_P2; end
              ST_P2: begin
                t2_q    <= ares;
                state_q <= asts.res_neg ? ST_OUT : ST_P3;
              end
              ST_P3: begin proj_q <= sat_u32(ares); state_q <= ST_OUT; end
              default: state_q <= ST_OUT;
            endcase
          end else begin
            issued_q <= 1'b1;
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SUMS || state_q == ST_CHECK))
    else $error("accepted request did not start processing");

  a_r2_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[147:131] <= R2_ONE))
    else $error("R-squared above one");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[2]) |-> (m_axis_tdata[211:3] == '0))
    else $error("invalid fit carries nonzero fields");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    actl.start |=> !actl.start)
    else $error("arithmetic unit started twice in a row");
`endif

endmodule
